/* src/lswc_pkg.sv */
`default_nettype none

package lswc_pkg;

    typedef logic [3:0] t_code;

    typedef struct packed {
        logic busy;
        logic done;
    } t_xing_sts;

    localparam t_code CODE_LEFT   = 4'b0001;
    localparam t_code CODE_BOTTOM = 4'b0010;
    localparam t_code CODE_RIGHT  = 4'b0100;
    localparam t_code CODE_TOP    = 4'b1000;
    localparam t_code CODE_NONE   = 4'b0000;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX = 2'd3;

    localparam int X_MIN_RST = 100;
    localparam int Y_MIN_RST = 10;
    localparam int X_MAX_RST = 260;
    localparam int Y_MAX_RST = 90;

    localparam int MAX_MOVES = 8;
    localparam int MOVE_BITS = $clog2(MAX_MOVES + 1);

endpackage

`default_nettype wire

/* src/line_segment_window_clipper.sv */
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_start_x, i_start_y, i_end_x, i_end_y
// result    out        o_valid / i_ready    o_accepted, o_clip_start_x .. o_clip_end_y
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// The result loads after acceptance once m endpoint moves are done (m = 0 to 8), and the next
// request is taken in the cycle after the result loads; the shared crossing unit (one multiply,
// then a one-bit-per-cycle restoring divide) does the work of each move.
// Synchronous active-low reset restores the window to 100, 10, 260, 90.
// One result register lets a new request enter while a result waits.
// o_ready is low from acceptance until the result is loaded; a full result register holds.
`default_nettype none

module line_segment_window_clipper #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [COORD_BITS-1:0]         i_start_x,
    input  wire logic signed [COORD_BITS-1:0]         i_start_y,
    input  wire logic signed [COORD_BITS-1:0]         i_end_x,
    input  wire logic signed [COORD_BITS-1:0]         i_end_y,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic                                      o_accepted,
    output logic signed [COORD_BITS-1:0]              o_clip_start_x,
    output logic signed [COORD_BITS-1:0]              o_clip_start_y,
    output logic signed [COORD_BITS-1:0]              o_clip_end_x,
    output logic signed [COORD_BITS-1:0]              o_clip_end_y,
    input  wire logic                                 i_cfg_we,
    input  wire logic [lswc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic signed [COORD_BITS-1:0]         i_cfg_data
);
    import lswc_pkg::*;

    localparam int W = COORD_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]             r_state;
    logic [MOVE_BITS-1:0]   r_moves;
    logic signed [W-1:0]    r_xmin;
    logic signed [W-1:0]    r_ymin;
    logic signed [W-1:0]    r_xmax;
    logic signed [W-1:0]    r_ymax;
    logic signed [W-1:0]    r_x1;
    logic signed [W-1:0]    r_y1;
    logic signed [W-1:0]    r_x2;
    logic signed [W-1:0]    r_y2;
    logic                   r_first;
    logic                   r_hor;
    logic signed [W-1:0]    r_edge;
    logic                   r_ovalid;
    logic                   r_oacc;
    logic signed [W-1:0]    r_osx;
    logic signed [W-1:0]    r_osy;
    logic signed [W-1:0]    r_oex;
    logic signed [W-1:0]    r_oey;

    t_code                  w_c1;
    t_code                  w_c2;
    t_code                  w_co;
    logic                   w_hor;
    logic signed [W-1:0]    w_edge;
    logic                   w_acc;
    logic                   w_rej;
    logic                   w_settle;
    logic                   w_oslot;
    logic                   w_load;
    logic                   w_start;
    logic signed [W-1:0]    w_a0;
    logic signed [W-1:0]    w_b0;
    logic signed [W-1:0]    w_a1;
    logic signed [W-1:0]    w_b1;
    logic signed [W-1:0]    w_res;
    logic signed [W-1:0]    w_nx;
    logic signed [W-1:0]    w_ny;
    t_xing_sts              w_sts;

    function automatic t_code f_code(
        input logic signed [W-1:0] x,
        input logic signed [W-1:0] y,
        input logic signed [W-1:0] xmin,
        input logic signed [W-1:0] ymin,
        input logic signed [W-1:0] xmax,
        input logic signed [W-1:0] ymax
    );
        t_code c;
        c = CODE_NONE;
        if (x < xmin) c = c | CODE_LEFT;
        if (y < ymin) c = c | CODE_BOTTOM;
        if (x > xmax) c = c | CODE_RIGHT;
        if (y > ymax) c = c | CODE_TOP;
        return c;
    endfunction

    assign w_c1 = f_code(r_x1, r_y1, r_xmin, r_ymin, r_xmax, r_ymax);
    assign w_c2 = f_code(r_x2, r_y2, r_xmin, r_ymin, r_xmax, r_ymax);
    assign w_co = (w_c1 != CODE_NONE) ? w_c1 : w_c2;

    assign w_hor  = ((w_co & CODE_TOP) == CODE_NONE) && ((w_co & CODE_BOTTOM) == CODE_NONE);
    assign w_edge = ((w_co & CODE_TOP) != CODE_NONE)    ? r_ymax :
                    ((w_co & CODE_BOTTOM) != CODE_NONE) ? r_ymin :
                    ((w_co & CODE_RIGHT) != CODE_NONE)  ? r_xmax : r_xmin;

    assign w_a0 = w_hor ? r_y1 : r_x1;
    assign w_b0 = w_hor ? r_x1 : r_y1;
    assign w_a1 = w_hor ? r_y2 : r_x2;
    assign w_b1 = w_hor ? r_x2 : r_y2;

    assign w_acc    = (w_c1 == CODE_NONE) && (w_c2 == CODE_NONE);
    assign w_rej    = !w_acc && (((w_c1 & w_c2) != CODE_NONE)
                                 || (r_moves == MOVE_BITS'(MAX_MOVES)));
    assign w_settle = w_acc || w_rej;
    assign w_oslot  = !r_ovalid || i_ready;
    assign w_load   = (r_state == S_EVAL) && w_settle && w_oslot;
    assign w_start  = (r_state == S_EVAL) && !w_settle;

    assign w_nx = r_hor ? r_edge : w_res;
    assign w_ny = r_hor ? w_res : r_edge;

    lswc_xing #(
        .W (W)
    ) u_xing (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_a0     (w_a0),
        .i_b0     (w_b0),
        .i_a1     (w_a1),
        .i_b1     (w_b1),
        .i_edge   (w_edge),
        .o_result (w_res),
        .o_sts    (w_sts)
    );

    assign o_ready        = r_state == S_IDLE;
    assign o_valid        = r_ovalid;
    assign o_accepted     = r_oacc;
    assign o_clip_start_x = r_osx;
    assign o_clip_start_y = r_osy;
    assign o_clip_end_x   = r_oex;
    assign o_clip_end_y   = r_oey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xmin <= W'(X_MIN_RST);
            r_ymin <= W'(Y_MIN_RST);
            r_xmax <= W'(X_MAX_RST);
            r_ymax <= W'(Y_MAX_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_X_MIN: r_xmin <= i_cfg_data;
                REG_Y_MIN: r_ymin <= i_cfg_data;
                REG_X_MAX: r_xmax <= i_cfg_data;
                REG_Y_MAX: r_ymax <= i_cfg_data;
                default:   r_xmin <= r_xmin;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_moves  <= '0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_moves <= '0;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_settle) begin
                        if (w_oslot) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_sts.done) begin
                        r_moves <= r_moves + 1'b1;
                        r_state <= S_EVAL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_x1 <= i_start_x;
                    r_y1 <= i_start_y;
                    r_x2 <= i_end_x;
                    r_y2 <= i_end_y;
                end
            end
            S_EVAL: begin
                if (w_settle && w_oslot) begin
                    r_oacc <= w_acc;
                    r_osx  <= w_acc ? r_x1 : '0;
                    r_osy  <= w_acc ? r_y1 : '0;
                    r_oex  <= w_acc ? r_x2 : '0;
                    r_oey  <= w_acc ? r_y2 : '0;
                end
                if (!w_settle) begin
                    r_first <= w_c1 != CODE_NONE;
                    r_hor   <= w_hor;
                    r_edge  <= w_edge;
                end
            end
            S_WAIT: begin
                if (w_sts.done) begin
                    if (r_first) begin
                        r_x1 <= w_nx;
                        r_y1 <= w_ny;
                    end else begin
                        r_x2 <= w_nx;
                        r_y2 <= w_ny;
                    end
                end
            end
            default: begin
                r_oacc <= r_oacc;
            end
        endcase
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_WAIT))
        else $error("crossing result outside wait state");

    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_sts.busy)
        else $error("crossing started while unit busy");

    a_move_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> (r_moves < MOVE_BITS'(MAX_MOVES)))
        else $error("move count past limit");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> ((o_clip_start_x == '0) && (o_clip_start_y == '0)
                                      && (o_clip_end_x == '0) && (o_clip_end_y == '0)))
        else $error("rejected result with nonzero coordinates");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready while a request is in flight");

endmodule

`default_nettype wire

/* src/lswc_xing.sv */
`default_nettype none

module lswc_xing #(
    parameter int W = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [W-1:0]  i_a0,
    input  wire logic signed [W-1:0]  i_b0,
    input  wire logic signed [W-1:0]  i_a1,
    input  wire logic signed [W-1:0]  i_b1,
    input  wire logic signed [W-1:0]  i_edge,
    output logic signed [W-1:0]       o_result,
    output lswc_pkg::t_xing_sts       o_sts
);
    import lswc_pkg::*;

    localparam int CW = $clog2(W + 2);

    localparam logic [1:0] X_IDLE = 2'd0;
    localparam logic [1:0] X_MUL  = 2'd1;
    localparam logic [1:0] X_DIV  = 2'd2;
    localparam logic [1:0] X_FIN  = 2'd3;

    logic [1:0]          r_state;
    logic [CW-1:0]       r_cnt;
    logic [W:0]          r_m1;
    logic [W:0]          r_m2;
    logic [W:0]          r_md;
    logic                r_neg;
    logic                r_dz;
    logic signed [W-1:0] r_a0;
    logic [W+1:0]        r_rem;
    logic [W:0]          r_lo;

    logic signed [W:0]   w_n1;
    logic signed [W:0]   w_n2;
    logic signed [W:0]   w_d;
    logic [W:0]          w_m1;
    logic [W:0]          w_m2;
    logic [W:0]          w_md;
    logic [2*W+1:0]      w_prod;
    logic [W+1:0]        w_sh;
    logic [W+1:0]        w_diff;
    logic                w_ge;
    logic [W:0]          w_q;
    logic signed [W+1:0] w_sum;

    assign w_n1 = {i_a1[W-1], i_a1} - {i_a0[W-1], i_a0};
    assign w_n2 = {i_edge[W-1], i_edge} - {i_b0[W-1], i_b0};
    assign w_d  = {i_b1[W-1], i_b1} - {i_b0[W-1], i_b0};
    assign w_m1 = w_n1[W] ? (~w_n1 + 1'b1) : w_n1;
    assign w_m2 = w_n2[W] ? (~w_n2 + 1'b1) : w_n2;
    assign w_md = w_d[W]  ? (~w_d + 1'b1)  : w_d;

    assign w_prod = {{(W+1){1'b0}}, r_m1} * {{(W+1){1'b0}}, r_m2};

    assign w_sh   = {r_rem[W:0], r_lo[W]};
    assign w_ge   = w_sh >= {1'b0, r_md};
    assign w_diff = w_sh - {1'b0, r_md};

    assign w_q   = (r_lo > r_m1) ? r_m1 : r_lo;
    assign w_sum = r_neg ? ({{2{r_a0[W-1]}}, r_a0} - {1'b0, w_q})
                         : ({{2{r_a0[W-1]}}, r_a0} + {1'b0, w_q});

    assign o_result   = r_dz ? r_a0 : w_sum[W-1:0];
    assign o_sts.busy = r_state != X_IDLE;
    assign o_sts.done = r_state == X_FIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= X_IDLE;
        end else begin
            case (r_state)
                X_IDLE: begin
                    if (i_start) begin
                        r_state <= X_MUL;
                    end
                end
                X_MUL: begin
                    r_state <= X_DIV;
                end
                X_DIV: begin
                    if (r_cnt == CW'(W)) begin
                        r_state <= X_FIN;
                    end
                end
                X_FIN: begin
                    r_state <= X_IDLE;
                end
                default: begin
                    r_state <= X_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            X_IDLE: begin
                if (i_start) begin
                    r_m1  <= w_m1;
                    r_m2  <= w_m2;
                    r_md  <= w_md;
                    r_dz  <= w_d == '0;
                    r_neg <= (w_n1[W] != w_n2[W]) != w_d[W];
                    r_a0  <= i_a0;
                end
            end
            X_MUL: begin
                r_rem <= {1'b0, w_prod[2*W+1:W+1]};
                r_lo  <= w_prod[W:0];
                r_cnt <= '0;
            end
            X_DIV: begin
                r_rem <= w_ge ? w_diff : w_sh;
                r_lo  <= {r_lo[W-1:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

`default_nettype wire
